>>> rtl/core/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, codes and helpers for the rotor stack cipher core.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int LETTERS    = 26;
    localparam int ROTORS_DEF = 3;

    typedef enum logic [2:0] {
        FN_LOAD = 3'd0,
        FN_SET  = 3'd1,
        FN_TICK = 3'd2,
        FN_FWD  = 3'd3,
        FN_BWD  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_READ,
        ST_THRU,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic set_wr;
        logic pass_init;
        logic rd_en;
        logic thru;
        logic step;
        logic out_load;
    } rsc_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       ticks_zero;
        logic       tick_last;
        logic       rotor_last;
        logic       out_free;
    } rsc_status_t;

    // v < 78
    function automatic logic [4:0] mod26(input logic [6:0] v);
        logic [6:0] r;
        if (v >= 7'd52)
        begin
            r = v - 7'd52;
        end
        else if (v >= 7'd26)
        begin
            r = v - 7'd26;
        end
        else
        begin
            r = v;
        end
        return r[4:0];
    endfunction

endpackage

>>> rtl/core/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: decodes each beat, runs steps and rotor passes, hands off result.
// ----------------------------------------------------------------------------
module rsc_ctrl
    import rsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rsc_status_t status,
    output rsc_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (status.func) inside
                    FN_TICK:
                    begin
                        state_next = status.ticks_zero ? ST_DONE : ST_TICK;
                    end
                    FN_FWD, FN_BWD:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_TICK:
            begin
                if (status.tick_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_THRU;
            end
            ST_THRU:
            begin
                state_next = status.rotor_last ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.load_wr   = (status.func == FN_LOAD);
                cmd.set_wr    = (status.func == FN_SET);
                cmd.pass_init = (status.func == FN_FWD) || (status.func == FN_BWD);
            end
            ST_TICK:
            begin
                cmd.step = 1'b1;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_THRU:
            begin
                cmd.thru = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("accepted beat not decoded");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over pending beat");

endmodule

>>> rtl/core/rsc_datapath.sv
// ----------------------------------------------------------------------------
// rsc_datapath
// Rotor state, wiring memories, stepping logic, pass arithmetic, result reg.
// ----------------------------------------------------------------------------
module rsc_datapath
    import rsc_pkg::*;
#(
    parameter int ROTORS = ROTORS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  rsc_cmd_t     cmd,
    output rsc_status_t  status,
    input  logic [2:0]   func,
    input  logic [1:0]   rotor_select,
    input  logic [4:0]   wiring_entry,
    input  logic [4:0]   wiring_value,
    input  logic [4:0]   ring_offset,
    input  logic [4:0]   start_position,
    input  logic [25:0]  notch_mask,
    input  logic [4:0]   tick_count,
    input  logic [4:0]   in_letter,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [4:0]   out_letter,
    output logic [4:0]   selected_position
);

    localparam int RIDX_W = (ROTORS > 1) ? $clog2(ROTORS) : 1;
    localparam int DEPTH  = ROTORS * LETTERS;
    localparam int ADDR_W = $clog2(DEPTH);

    // captured beat
    logic [2:0]        func_reg;
    logic [1:0]        sel_reg;
    logic [4:0]        entry_reg;
    logic [4:0]        value_reg;
    logic [4:0]        ring_in_reg;
    logic [4:0]        start_reg;
    logic [25:0]       notch_in_reg;
    logic [4:0]        letter_reg;
    logic [4:0]        tick_cnt_reg;
    logic [4:0]        tick_cnt_next;

    // rotor state
    logic [4:0]        pos_reg   [ROTORS];
    logic [4:0]        pos_next  [ROTORS];
    logic [4:0]        ring_reg  [ROTORS];
    logic [4:0]        ring_next [ROTORS];
    logic [25:0]       notch_reg [ROTORS];
    logic [25:0]       notch_next[ROTORS];

    // pass
    logic [4:0]        x_reg;
    logic [RIDX_W-1:0] rotor_reg;
    logic              bwd_reg;
    logic [4:0]        rd_w_reg;
    logic [4:0]        rd_i_reg;

    logic [4:0]        wiring_mem [DEPTH];
    logic [4:0]        inverse_mem[DEPTH];

    // result
    logic              out_valid_reg;
    logic [4:0]        out_letter_reg;
    logic [4:0]        sel_pos_reg;

    logic              sel_ok;
    logic [RIDX_W-1:0] sel_idx;
    logic [RIDX_W-1:0] rd_sel;
    logic              rd_ok;
    logic [4:0]        pos_cur;
    logic [4:0]        ring_cur;
    logic [4:0]        idx;
    logic [4:0]        w_cur;
    logic [4:0]        x_thru;
    logic              rotor_last;
    logic              is_pass;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] inv_addr;
    logic              notch_at[ROTORS];
    logic              adv     [ROTORS];

    assign sel_ok  = (32'(sel_reg) < ROTORS);
    assign sel_idx = RIDX_W'(sel_reg);
    assign rd_sel  = cmd.out_load ? sel_idx : rotor_reg;
    assign rd_ok   = cmd.out_load ? sel_ok : 1'b1;

    always_comb
    begin
        pos_cur  = '0;
        ring_cur = '0;
        for (int i = 0; i < ROTORS; i++)
        begin
            if (rd_ok && (rd_sel == RIDX_W'(i)))
            begin
                pos_cur  = pos_reg[i];
                ring_cur = ring_reg[i];
            end
        end
    end

    assign idx    = mod26(7'(x_reg) + 7'(pos_cur) + 7'(LETTERS) - 7'(ring_cur));
    assign w_cur  = bwd_reg ? rd_i_reg : rd_w_reg;
    assign x_thru = mod26(7'(w_cur) + 7'(ring_cur) + 7'(LETTERS) - 7'(pos_cur));

    assign rd_addr  = ADDR_W'(rotor_reg) * ADDR_W'(LETTERS) + ADDR_W'(idx);
    assign wr_addr  = ADDR_W'(sel_reg) * ADDR_W'(LETTERS) + ADDR_W'(entry_reg);
    assign inv_addr = ADDR_W'(sel_reg) * ADDR_W'(LETTERS) + ADDR_W'(value_reg);

    assign rotor_last = bwd_reg ? (rotor_reg == '0) : (rotor_reg == RIDX_W'(ROTORS - 1));
    assign is_pass    = (func_reg == FN_FWD) || (func_reg == FN_BWD);

    always_comb
    begin
        status.func       = func_reg;
        status.ticks_zero = (tick_cnt_reg == '0);
        status.tick_last  = (tick_cnt_reg == 5'd1);
        status.rotor_last = rotor_last;
        status.out_free   = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func;
            sel_reg      <= rotor_select;
            entry_reg    <= wiring_entry;
            value_reg    <= mod26({2'b00, wiring_value});
            ring_in_reg  <= mod26({2'b00, ring_offset});
            start_reg    <= mod26({2'b00, start_position});
            notch_in_reg <= notch_mask;
            letter_reg   <= in_letter;
        end
    end

    always_comb
    begin
        tick_cnt_next = tick_cnt_reg;
        if (cmd.capture)
        begin
            tick_cnt_next = tick_count;
        end
        else if (cmd.step)
        begin
            tick_cnt_next = tick_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_cnt_reg <= '0;
        end
        else
        begin
            tick_cnt_reg <= tick_cnt_next;
        end
    end

    // single step: carry out of a rotor at its notch, double step of middle rotors
    always_comb
    begin
        for (int i = 0; i < ROTORS; i++)
        begin
            notch_at[i] = notch_reg[i][pos_reg[i]];
        end
        for (int i = 0; i < ROTORS; i++)
        begin
            adv[i] = (i == 0)
                   || ((i < ROTORS - 1) && notch_at[i])
                   || ((i > 0) && notch_at[(i > 0) ? i - 1 : 0]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < ROTORS; i++)
        begin
            pos_next[i]   = pos_reg[i];
            ring_next[i]  = ring_reg[i];
            notch_next[i] = notch_reg[i];
            if (cmd.set_wr && sel_ok && (sel_idx == RIDX_W'(i)))
            begin
                pos_next[i]   = start_reg;
                ring_next[i]  = ring_in_reg;
                notch_next[i] = notch_in_reg;
            end
            else if (cmd.step && adv[i])
            begin
                pos_next[i] = (pos_reg[i] == 5'd25) ? 5'd0 : pos_reg[i] + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROTORS; i++)
            begin
                pos_reg[i]   <= '0;
                ring_reg[i]  <= '0;
                notch_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < ROTORS; i++)
            begin
                pos_reg[i]   <= pos_next[i];
                ring_reg[i]  <= ring_next[i];
                notch_reg[i] <= notch_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && sel_ok && (entry_reg < 5'd26))
        begin
            wiring_mem[wr_addr]   <= value_reg;
            inverse_mem[inv_addr] <= entry_reg;
        end
        if (cmd.rd_en)
        begin
            rd_w_reg <= wiring_mem[rd_addr];
            rd_i_reg <= inverse_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotor_reg <= '0;
        end
        else if (cmd.pass_init)
        begin
            rotor_reg <= (func_reg == FN_BWD) ? RIDX_W'(ROTORS - 1) : '0;
        end
        else if (cmd.thru && !rotor_last)
        begin
            rotor_reg <= bwd_reg ? rotor_reg - RIDX_W'(1) : rotor_reg + RIDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pass_init)
        begin
            x_reg   <= mod26({2'b00, letter_reg});
            bwd_reg <= (func_reg == FN_BWD);
        end
        else if (cmd.thru)
        begin
            x_reg <= x_thru;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_letter_reg <= is_pass ? x_reg : 5'd0;
            sel_pos_reg    <= pos_cur;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_letter        = out_letter_reg;
    assign selected_position = sel_pos_reg;

    a_rotor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rotor_reg) < ROTORS)
        else $error("rotor index out of range");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> tick_cnt_reg != '0)
        else $error("step with no ticks left");

    a_thru_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.thru |-> $past(cmd.rd_en))
        else $error("pass arithmetic without table read");

endmodule

>>> rtl/core/rotor_stack_cipher_core.sv
// ----------------------------------------------------------------------------
// rotor_stack_cipher_core
// Stack of substitution rotors with notch carry and middle-rotor double step.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one command beat: func selects load
// of a wiring entry, rotor set, tick, forward pass or backward pass. Output
// channel (out_valid/out_ready) returns exactly one beat per command:
// out_letter (enciphered letter for passes, else 0) and selected_position
// (position of rotor rotor_select after the command, 0 if out of the stack).
// Commands run one at a time; in_ready is high only when the sequencer idles.
// After decode, load, set and unused codes go to the result stage; a tick
// takes tick_count single steps, one per cycle; a pass does a registered
// table read, then arithmetic, for each rotor in turn.
// out_valid rises as the result register loads; the sequencer then idles
// and takes the next command.
// A stalled receiver holds the result; the next command is taken while it
// waits, and its result is held back until the output register frees.
// Reset clears positions, rings and notch masks; wiring memories are not
// cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module rotor_stack_cipher_core
    import rsc_pkg::*;
#(
    parameter int ROTORS = ROTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  func,
    input  logic [1:0]  rotor_select,
    input  logic [4:0]  wiring_entry,
    input  logic [4:0]  wiring_value,
    input  logic [4:0]  ring_offset,
    input  logic [4:0]  start_position,
    input  logic [25:0] notch_mask,
    input  logic [4:0]  tick_count,
    input  logic [4:0]  in_letter,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  out_letter,
    output logic [4:0]  selected_position
);

    rsc_cmd_t    cmd;
    rsc_status_t status;

    rsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rsc_datapath #(
        .ROTORS (ROTORS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .func              (func),
        .rotor_select      (rotor_select),
        .wiring_entry      (wiring_entry),
        .wiring_value      (wiring_value),
        .ring_offset       (ring_offset),
        .start_position    (start_position),
        .notch_mask        (notch_mask),
        .tick_count        (tick_count),
        .in_letter         (in_letter),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_letter        (out_letter),
        .selected_position (selected_position)
    );

endmodule

>>> dv/rotor_stack_cipher_check.sv
// ----------------------------------------------------------------------------
// rotor_stack_cipher_check
// Watches both channels of the rotor stack core, predicts each result beat
// from its own copy of the wiring, rings, notches and positions, and compares
// every output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rotor_stack_cipher_check
    import rsc_pkg::*;
#(
    parameter int ROTORS = ROTORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  func,
    input  logic [1:0]  rotor_select,
    input  logic [4:0]  wiring_entry,
    input  logic [4:0]  wiring_value,
    input  logic [4:0]  ring_offset,
    input  logic [4:0]  start_position,
    input  logic [25:0] notch_mask,
    input  logic [4:0]  tick_count,
    input  logic [4:0]  in_letter,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [4:0]  out_letter,
    input  logic [4:0]  selected_position,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0] letter;
        logic [4:0] position;
    } cipher_beat_t;

    logic [4:0]  wiring_fwd [ROTORS][LETTERS];
    logic [4:0]  wiring_inv [ROTORS][LETTERS];
    logic [4:0]  rotor_pos [ROTORS];
    logic [4:0]  rotor_ring [ROTORS];
    logic [25:0] rotor_notch [ROTORS];

    cipher_beat_t expected_beats[$];
    int           fail_count = 0;
    int           beat_index = 0;

    function automatic int through_rotor(input logic inverse, input int r, input int x);
        int idx;
        int w;
        idx = (x + rotor_pos[r] + LETTERS - rotor_ring[r]) % LETTERS;
        w   = inverse ? int'(wiring_inv[r][idx]) : int'(wiring_fwd[r][idx]);
        w   = w % LETTERS;
        return (w + rotor_ring[r] + LETTERS - rotor_pos[r]) % LETTERS;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
        begin
            $display("mismatch at beat %0d: %s", beat_index, what);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_beat_t       want;
        logic [ROTORS-1:0]  advance;
        int                 letter;
        logic               sel_ok;
        if (!rst_n)
        begin
            for (int r = 0; r < ROTORS; r++)
            begin
                rotor_pos[r]   = '0;
                rotor_ring[r]  = '0;
                rotor_notch[r] = '0;
            end
            expected_beats.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat letter %0d position %0d",
                                              out_letter, selected_position));
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_letter !== want.letter)
                    begin
                        report_mismatch($sformatf("out_letter %0d, predicted %0d",
                                                  out_letter, want.letter));
                    end
                    if (selected_position !== want.position)
                    begin
                        report_mismatch($sformatf("selected_position %0d, predicted %0d",
                                                  selected_position, want.position));
                    end
                end
                beat_index++;
            end

            if (in_valid && in_ready)
            begin
                sel_ok      = rotor_select < ROTORS;
                want.letter = '0;
                case (func)
                    FN_LOAD:
                    begin
                        if (sel_ok && wiring_entry < LETTERS)
                        begin
                            wiring_fwd[rotor_select][wiring_entry] =
                                5'(wiring_value % LETTERS);
                            wiring_inv[rotor_select][wiring_value % LETTERS] = wiring_entry;
                        end
                    end
                    FN_SET:
                    begin
                        if (sel_ok)
                        begin
                            rotor_ring[rotor_select]  = 5'(ring_offset % LETTERS);
                            rotor_pos[rotor_select]   = 5'(start_position % LETTERS);
                            rotor_notch[rotor_select] = notch_mask;
                        end
                    end
                    FN_TICK:
                    begin
                        repeat (tick_count)
                        begin
                            advance    = '0;
                            advance[0] = 1'b1;
                            for (int i = 0; i + 1 < ROTORS; i++)
                            begin
                                if (rotor_notch[i][rotor_pos[i]])
                                begin
                                    advance[i]     = 1'b1;
                                    advance[i + 1] = 1'b1;
                                end
                            end
                            for (int i = 0; i < ROTORS; i++)
                            begin
                                if (advance[i])
                                begin
                                    rotor_pos[i] = (rotor_pos[i] == LETTERS - 1) ?
                                                   5'd0 : rotor_pos[i] + 5'd1;
                                end
                            end
                        end
                    end
                    FN_FWD:
                    begin
                        letter = in_letter % LETTERS;
                        for (int r = 0; r < ROTORS; r++)
                        begin
                            letter = through_rotor(1'b0, r, letter);
                        end
                        want.letter = 5'(letter);
                    end
                    FN_BWD:
                    begin
                        letter = in_letter % LETTERS;
                        for (int r = ROTORS - 1; r >= 0; r--)
                        begin
                            letter = through_rotor(1'b1, r, letter);
                        end
                        want.letter = 5'(letter);
                    end
                    default:
                    begin
                    end
                endcase
                if (sel_ok)
                begin
                    want.position = rotor_pos[rotor_select];
                end
                else
                begin
                    want.position = '0;
                end
                expected_beats.push_back(want);
            end

            outstanding <= expected_beats.size();
            mismatches  <= fail_count;
        end
    end

endmodule

>>> dv/rotor_stack_cipher_core_test.sv
// ----------------------------------------------------------------------------
// rotor_stack_cipher_core_test
// Loads full wiring for every rotor, runs a directed pass over stepping,
// carry, double step and ignored commands, then a long random mix of loads,
// sets, ticks and passes under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module rotor_stack_cipher_core_test
    import rsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ROTORS          = 3;
    localparam int         RANDOM_ITEMS    = 1600;
    localparam int         DRAIN_AT        = 500;
    localparam int         HOLD_AT         = 900;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         TAIL_CYCLES     = 40;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FN_UNUSED_MID   = 3'd6;
    localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;
    localparam logic [25:0] NOTCH_ALL      = 26'h3FF_FFFF;

    typedef struct packed {
        logic [2:0]  fn;
        logic [1:0]  sel;
        logic [4:0]  entry;
        logic [4:0]  value;
        logic [4:0]  ring;
        logic [4:0]  start;
        logic [25:0] notch;
        logic [4:0]  ticks;
        logic [4:0]  letter;
    } rotor_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  func;
    logic [1:0]  rotor_select;
    logic [4:0]  wiring_entry;
    logic [4:0]  wiring_value;
    logic [4:0]  ring_offset;
    logic [4:0]  start_position;
    logic [25:0] notch_mask;
    logic [4:0]  tick_count;
    logic [4:0]  in_letter;
    logic        out_valid;
    logic        out_ready;
    logic [4:0]  out_letter;
    logic [4:0]  selected_position;
    int          mismatches;
    int          outstanding;

    int sent_count  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    rotor_stack_cipher_core #(.ROTORS(ROTORS)) dut (.*);

    rotor_stack_cipher_check #(.ROTORS(ROTORS)) u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // receiver: short runs and stalls, long ready stretches, one long hold-off
    initial
    begin
        int  run_len;
        int  stall_len;
        bit  held;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && sent_count >= HOLD_AT)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (stall_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    function automatic rotor_cmd_t cmd_of(input logic [2:0] fn, input logic [1:0] sel,
                                          input logic [4:0] entry, input logic [4:0] value,
                                          input logic [4:0] ring, input logic [4:0] start,
                                          input logic [25:0] notch, input logic [4:0] ticks,
                                          input logic [4:0] letter);
        rotor_cmd_t c;
        c.fn     = fn;
        c.sel    = sel;
        c.entry  = entry;
        c.value  = value;
        c.ring   = ring;
        c.start  = start;
        c.notch  = notch;
        c.ticks  = ticks;
        c.letter = letter;
        return c;
    endfunction

    // one beat, sent in bursts with random gaps between bursts
    task automatic send_command(input rotor_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid       <= 1'b1;
        func           <= c.fn;
        rotor_select   <= c.sel;
        wiring_entry   <= c.entry;
        wiring_value   <= c.value;
        ring_offset    <= c.ring;
        start_position <= c.start;
        notch_mask     <= c.notch;
        tick_count     <= c.ticks;
        in_letter      <= c.letter;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial
    begin
        rotor_cmd_t cmd;
        int         perm [LETTERS];
        int         pick;
        int         j;
        int         tmp;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        func           <= FN_LOAD;
        rotor_select   <= '0;
        wiring_entry   <= '0;
        wiring_value   <= '0;
        ring_offset    <= '0;
        start_position <= '0;
        notch_mask     <= '0;
        tick_count     <= '0;
        in_letter      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every wiring entry written before any pass reads it
        for (int r = 0; r < ROTORS; r++)
        begin
            for (int e = 0; e < LETTERS; e++)
            begin
                perm[e] = e;
            end
            for (int e = LETTERS - 1; e > 0; e--)
            begin
                j       = $urandom_range(0, e);
                tmp     = perm[e];
                perm[e] = perm[j];
                perm[j] = tmp;
            end
            for (int e = 0; e < LETTERS; e++)
            begin
                send_command(cmd_of(FN_LOAD, 2'(r), 5'(e), 5'(perm[e]), 0, 0, 0, 0, 0));
            end
        end

        send_command(cmd_of(FN_FWD, 0, 0, 0, 0, 0, 0, 0, 0));
        send_command(cmd_of(FN_BWD, 2, 0, 0, 0, 0, 0, 0, 25));
        // carry from rotor 0 at 25, rotor 1 notch at 4 for the double step
        send_command(cmd_of(FN_SET, 0, 0, 0, 0, 24, 26'd1 << 25, 0, 0));
        send_command(cmd_of(FN_SET, 1, 0, 0, 3, 3, 26'd1 << 4, 0, 0));
        send_command(cmd_of(FN_SET, 2, 0, 0, 25, 0, 0, 0, 0));
        send_command(cmd_of(FN_TICK, 0, 0, 0, 0, 0, 0, 1, 0));
        send_command(cmd_of(FN_TICK, 1, 0, 0, 0, 0, 0, 1, 0));
        send_command(cmd_of(FN_TICK, 2, 0, 0, 0, 0, 0, 1, 0));
        send_command(cmd_of(FN_TICK, 1, 0, 0, 0, 0, 0, 0, 0));
        send_command(cmd_of(FN_TICK, 0, 0, 0, 0, 0, 0, 31, 0));
        send_command(cmd_of(FN_FWD, 1, 0, 0, 0, 0, 0, 0, 31));
        send_command(cmd_of(FN_BWD, 0, 0, 0, 0, 0, 0, 0, 26));
        // select beyond the stack, entry beyond the alphabet
        send_command(cmd_of(FN_SET, 3, 0, 0, 7, 9, NOTCH_ALL, 0, 0));
        send_command(cmd_of(FN_LOAD, 3, 0, 1, 0, 0, 0, 0, 0));
        send_command(cmd_of(FN_LOAD, 0, 31, 3, 0, 0, 0, 0, 0));
        // value wraps to 5, breaking the permutation
        send_command(cmd_of(FN_LOAD, 1, 2, 31, 0, 0, 0, 0, 0));
        send_command(cmd_of(FN_BWD, 1, 0, 0, 0, 0, 0, 0, 5));
        send_command(cmd_of(FN_UNUSED_FIRST, 0, 0, 0, 0, 0, 0, 3, 7));
        send_command(cmd_of(FN_UNUSED_MID, 3, 0, 0, 0, 0, 0, 0, 0));
        send_command(cmd_of(FN_UNUSED_LAST, 1, 0, 0, 0, 0, 0, 0, 31));
        send_command(cmd_of(FN_SET, 0, 0, 0, 31, 31, NOTCH_ALL, 0, 0));
        send_command(cmd_of(FN_TICK, 1, 0, 0, 0, 0, 0, 3, 0));
        send_command(cmd_of(FN_FWD, 2, 0, 0, 0, 0, 0, 0, 13));
        send_command(cmd_of(FN_SET, 2, 0, 0, 0, 25, NOTCH_ALL, 0, 0));
        send_command(cmd_of(FN_TICK, 2, 0, 0, 0, 0, 0, 2, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == DRAIN_AT)
            begin
                drain_results();
            end
            cmd.sel    = ($urandom_range(0, 9) == 0) ? 2'd3
                                                     : 2'($urandom_range(0, ROTORS - 1));
            cmd.entry  = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(26, 31))
                                                     : 5'($urandom_range(0, LETTERS - 1));
            cmd.value  = 5'($urandom_range(0, 31));
            cmd.ring   = 5'($urandom_range(0, 31));
            cmd.start  = 5'($urandom_range(0, 31));
            cmd.ticks  = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                     : 5'($urandom_range(1, 4));
            cmd.letter = 5'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0:       cmd.notch = '0;
                1:       cmd.notch = 26'd1 << $urandom_range(0, LETTERS - 1);
                2:       cmd.notch = 26'($urandom());
                default: cmd.notch = NOTCH_ALL;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                cmd.fn = FN_LOAD;
            end
            else if (pick < 14)
            begin
                cmd.fn = FN_SET;
            end
            else if (pick < 34)
            begin
                cmd.fn = FN_TICK;
            end
            else if (pick < 64)
            begin
                cmd.fn = FN_FWD;
            end
            else if (pick < 94)
            begin
                cmd.fn = FN_BWD;
            end
            else
            begin
                cmd.fn = 3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST));
            end
            send_command(cmd);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
